FILE: hdl/ptgi_pkg.sv
// ----------------------------------------------------------------------------
// Partition to global index package
// Widths, configuration register indexes and the configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package ptgi_pkg;

    localparam int PART_W  = 16;
    localparam int OFS_W   = 31;
    localparam int LEN_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;
    localparam int RANK_W  = 2;
    localparam int AXES    = 3;

    localparam logic [CIDX_W-1:0] CFG_ARRAY_RANK = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SPLIT_AXIS = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PART_LEN_0 = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_PART_LEN_1 = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PART_LEN_2 = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_FULL_LEN_1 = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_FULL_LEN_2 = 3'd6;

    typedef struct packed {
        logic [RANK_W-1:0] array_rank;
        logic [1:0]        split_axis;
        logic [LEN_W-1:0]  part_len_0;
        logic [LEN_W-1:0]  part_len_1;
        logic [LEN_W-1:0]  part_len_2;
        logic [LEN_W-1:0]  full_len_1;
        logic [LEN_W-1:0]  full_len_2;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/ptgi_if.sv
// ----------------------------------------------------------------------------
// Partition to global index channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptgi_in_if;
    logic                      valid;
    logic                      ready;
    logic [ptgi_pkg::PART_W-1:0] part_number;
    logic [ptgi_pkg::OFS_W-1:0]  local_offset;
    modport source (output valid, output part_number, output local_offset, input ready);
    modport sink (input valid, input part_number, input local_offset, output ready);
endinterface

interface ptgi_out_if;
    logic                       valid;
    logic                       ready;
    logic [ptgi_pkg::OFS_W-1:0] global_offset;
    logic                       overflowed;
    modport source (output valid, output global_offset, output overflowed, input ready);
    modport sink (input valid, input global_offset, input overflowed, output ready);
endinterface

interface ptgi_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ptgi_pkg::CIDX_W-1:0]  index;
    logic [ptgi_pkg::CDATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ptgi_cfg_regs.sv
// ----------------------------------------------------------------------------
// Partition to global index configuration registers
// Holds the seven configuration registers written over the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_cfg_regs (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_wr,
    input  wire [ptgi_pkg::CIDX_W-1:0]    i_index,
    input  wire [ptgi_pkg::CDATA_W-1:0]   i_data,
    output ptgi_pkg::t_cfg                o_cfg
);
    import ptgi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.array_rank <= RANK_W'(1);
            r_cfg.split_axis <= 2'd0;
            r_cfg.part_len_0 <= LEN_W'(1);
            r_cfg.part_len_1 <= LEN_W'(1);
            r_cfg.part_len_2 <= LEN_W'(1);
            r_cfg.full_len_1 <= LEN_W'(1);
            r_cfg.full_len_2 <= LEN_W'(1);
        end else if (i_wr) begin
            case (i_index)
                CFG_ARRAY_RANK: r_cfg.array_rank <= i_data[RANK_W-1:0];
                CFG_SPLIT_AXIS: r_cfg.split_axis <= i_data[1:0];
                CFG_PART_LEN_0: r_cfg.part_len_0 <= i_data[LEN_W-1:0];
                CFG_PART_LEN_1: r_cfg.part_len_1 <= i_data[LEN_W-1:0];
                CFG_PART_LEN_2: r_cfg.part_len_2 <= i_data[LEN_W-1:0];
                CFG_FULL_LEN_1: r_cfg.full_len_1 <= i_data[LEN_W-1:0];
                CFG_FULL_LEN_2: r_cfg.full_len_2 <= i_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/ptgi_div.sv
// ----------------------------------------------------------------------------
// Partition to global index pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_div #(
    parameter int SB_W = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [ptgi_pkg::OFS_W-1:0]    i_dividend,
    input  wire [ptgi_pkg::LEN_W-1:0]    i_divisor,
    input  wire [SB_W-1:0]               i_sb,
    output logic                         o_valid,
    output logic [ptgi_pkg::OFS_W-1:0]   o_quotient,
    output logic [ptgi_pkg::LEN_W-1:0]   o_remainder,
    output logic [SB_W-1:0]              o_sb
);
    import ptgi_pkg::*;

    localparam int STEPS = OFS_W;

    logic             r_vld [STEPS];
    logic [LEN_W-1:0] r_rem [STEPS];
    logic [OFS_W-1:0] r_acc [STEPS];
    logic [SB_W-1:0]  r_sb  [STEPS];

    logic             c_vld [STEPS+1];
    logic [LEN_W-1:0] c_rem [STEPS+1];
    logic [OFS_W-1:0] c_acc [STEPS+1];
    logic [SB_W-1:0]  c_sb  [STEPS+1];

    assign c_vld[0] = i_valid;
    assign c_rem[0] = '0;
    assign c_acc[0] = i_dividend;
    assign c_sb[0]  = i_sb;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [LEN_W:0]   trial;
        logic             q_bit;
        logic [LEN_W-1:0] n_rem;
        logic [OFS_W-1:0] n_acc;

        assign trial = {c_rem[k], c_acc[k][OFS_W-1]};
        assign q_bit = trial >= {1'b0, i_divisor};
        assign n_rem = q_bit ? LEN_W'(trial - {1'b0, i_divisor}) : trial[LEN_W-1:0];
        assign n_acc = {c_acc[k][OFS_W-2:0], q_bit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_acc[k] <= n_acc;
                r_sb[k]  <= c_sb[k];
            end
        end

        assign c_vld[k+1] = r_vld[k];
        assign c_rem[k+1] = r_rem[k];
        assign c_acc[k+1] = r_acc[k];
        assign c_sb[k+1]  = r_sb[k];
    end

    assign o_valid     = c_vld[STEPS];
    assign o_quotient  = c_acc[STEPS];
    assign o_remainder = c_rem[STEPS];
    assign o_sb        = c_sb[STEPS];

endmodule

`default_nettype wire

FILE: hdl/ptgi_combine.sv
// ----------------------------------------------------------------------------
// Partition to global index combine pipeline
// Offsets the split axis, weights coordinates by strides and sums them.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_combine (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  wire [ptgi_pkg::PART_W-1:0]  i_part,
    input  wire [ptgi_pkg::LEN_W-1:0]   i_rem_0,
    input  wire [ptgi_pkg::LEN_W-1:0]   i_rem_1,
    input  wire [ptgi_pkg::LEN_W-1:0]   i_rem_2,
    input  wire [ptgi_pkg::LEN_W-1:0]   i_split_ext,
    input  wire [ptgi_pkg::AXES-1:0]    i_split_sel,
    input  wire [31:0]                  i_stride_0,
    input  wire [ptgi_pkg::LEN_W-1:0]   i_stride_1,
    output logic                        o_valid,
    output logic [ptgi_pkg::OFS_W-1:0]  o_global_offset,
    output logic                        o_overflowed
);
    import ptgi_pkg::*;

    logic             r_a_vld;
    logic [31:0]      r_a_pe;
    logic [LEN_W-1:0] r_a_rem [AXES];

    logic             r_b_vld;
    logic [31:0]      r_b_crd [AXES];

    logic             r_c_vld;
    logic [63:0]      r_c_t0;
    logic [47:0]      r_c_t1;
    logic [31:0]      r_c_t2;

    logic             r_d_vld;
    logic [OFS_W-1:0] r_d_sum;
    logic             r_d_ovf;

    logic [OFS_W+1:0] n_sum;
    logic             n_ovf;

    assign n_sum = (OFS_W+2)'(r_c_t0[OFS_W-1:0]) + (OFS_W+2)'(r_c_t1[OFS_W-1:0])
                 + (OFS_W+2)'(r_c_t2[OFS_W-1:0]);
    assign n_ovf = (|r_c_t0[63:OFS_W]) | (|r_c_t1[47:OFS_W]) | r_c_t2[31]
                 | (|n_sum[OFS_W+1:OFS_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pe     <= 32'(i_part) * 32'(i_split_ext);
            r_a_rem[0] <= i_rem_0;
            r_a_rem[1] <= i_rem_1;
            r_a_rem[2] <= i_rem_2;
            for (int a = 0; a < AXES; a++) begin
                r_b_crd[a] <= 32'(r_a_rem[a]) + (i_split_sel[a] ? r_a_pe : 32'd0);
            end
            r_c_t0  <= 64'(r_b_crd[0]) * 64'(i_stride_0);
            r_c_t1  <= 48'(r_b_crd[1]) * 48'(i_stride_1);
            r_c_t2  <= r_b_crd[2];
            r_d_sum <= n_sum[OFS_W-1:0];
            r_d_ovf <= n_ovf;
        end
    end

    assign o_valid         = r_d_vld;
    assign o_global_offset = r_d_sum;
    assign o_overflowed    = r_d_ovf;

endmodule

`default_nettype wire

FILE: hdl/partition_to_global_index.sv
// ----------------------------------------------------------------------------
// Partition to global index
// Maps a flat index inside one partition to the flat row-major array index.
//
//   Channel  Role    Payload
//   i_in     sink    part_number, local_offset
//   o_out    source  global_offset, overflowed
//   i_cfg    sink    index, data (register write)
//
// One item is taken per cycle unless the output stalls; a stall freezes the
// whole pipeline, so nothing is dropped or repeated. The pipeline is three
// 31-stage dividers, one per axis, then four stages of offset, multiply and
// sum. Reset is synchronous and clears the valid bits and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_to_global_index #(
    parameter int MAX_RANK = 3
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    ptgi_in_if.sink   i_in,
    ptgi_out_if.source o_out,
    ptgi_cfg_if.sink  i_cfg
);
    import ptgi_pkg::*;

    t_cfg              cfg;
    logic              en;
    logic [RANK_W-1:0] rank_eff;
    logic [AXES-1:0]   used;
    logic [LEN_W-1:0]  dvs [AXES];
    logic [LEN_W-1:0]  split_ext;
    logic [AXES-1:0]   split_sel;
    logic [LEN_W-1:0]  stride_1;
    logic [LEN_W-1:0]  fl1_eff;
    logic [31:0]       r_stride_0;

    logic              v2, v1, v0;
    logic [OFS_W-1:0]  q2, q1;
    logic [LEN_W-1:0]  m2, m1, m0;
    logic [PART_W-1:0] sb2;
    logic [PART_W+LEN_W-1:0]   sb1;
    logic [PART_W+2*LEN_W-1:0] sb0;

    ptgi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );
    assign i_cfg.ready = 1'b1;

    always_comb begin
        rank_eff = (cfg.array_rank == '0) ? RANK_W'(1) : cfg.array_rank;
        if (rank_eff > RANK_W'(MAX_RANK)) begin
            rank_eff = RANK_W'(MAX_RANK);
        end
        for (int a = 0; a < AXES; a++) begin
            used[a] = RANK_W'(a) < rank_eff;
        end
    end

    assign dvs[0] = (used[0] && cfg.part_len_0 != '0) ? cfg.part_len_0 : LEN_W'(1);
    assign dvs[1] = (used[1] && cfg.part_len_1 != '0) ? cfg.part_len_1 : LEN_W'(1);
    assign dvs[2] = (used[2] && cfg.part_len_2 != '0) ? cfg.part_len_2 : LEN_W'(1);

    always_comb begin
        split_sel = '0;
        split_ext = '0;
        case (cfg.split_axis)
            2'd0: begin split_sel[0] = used[0]; split_ext = dvs[0]; end
            2'd1: begin split_sel[1] = used[1]; split_ext = dvs[1]; end
            2'd2: begin split_sel[2] = used[2]; split_ext = dvs[2]; end
            default: ;
        endcase
    end

    assign stride_1 = used[2] ? cfg.full_len_2 : LEN_W'(1);
    assign fl1_eff  = used[1] ? cfg.full_len_1 : LEN_W'(1);

    always_ff @(posedge i_clk) begin
        r_stride_0 <= 32'(stride_1) * 32'(fl1_eff);
    end

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    ptgi_div #(.SB_W(PART_W)) u_div2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in.valid),
        .i_dividend  (i_in.local_offset),
        .i_divisor   (dvs[2]),
        .i_sb        (i_in.part_number),
        .o_valid     (v2),
        .o_quotient  (q2),
        .o_remainder (m2),
        .o_sb        (sb2)
    );

    ptgi_div #(.SB_W(PART_W+LEN_W)) u_div1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (v2),
        .i_dividend  (q2),
        .i_divisor   (dvs[1]),
        .i_sb        ({sb2, m2}),
        .o_valid     (v1),
        .o_quotient  (q1),
        .o_remainder (m1),
        .o_sb        (sb1)
    );

    ptgi_div #(.SB_W(PART_W+2*LEN_W)) u_div0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (v1),
        .i_dividend  (q1),
        .i_divisor   (dvs[0]),
        .i_sb        ({sb1, m1}),
        .o_valid     (v0),
        .o_quotient  (),
        .o_remainder (m0),
        .o_sb        (sb0)
    );

    ptgi_combine u_comb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (v0),
        .i_part          (sb0[PART_W+2*LEN_W-1:2*LEN_W]),
        .i_rem_0         (m0),
        .i_rem_1         (sb0[LEN_W-1:0]),
        .i_rem_2         (sb0[2*LEN_W-1:LEN_W]),
        .i_split_ext     (split_ext),
        .i_split_sel     (split_sel),
        .i_stride_0      (r_stride_0),
        .i_stride_1      (stride_1),
        .o_valid         (o_out.valid),
        .o_global_offset (o_out.global_offset),
        .o_overflowed    (o_out.overflowed)
    );

endmodule

`default_nettype wire
